FILE: src/led_strip_fade_engine_defines.svh
// ============================================================================
// led_strip_fade_engine_defines
// Assertion macros shared by the fade engine RTL.
// ============================================================================
`ifndef LED_STRIP_FADE_ENGINE_DEFINES_SVH
`define LED_STRIP_FADE_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSFE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSFE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lsfe_pkg.sv
// ============================================================================
// lsfe_pkg
// Types and constants of the LED strip fade engine.
// ============================================================================
package lsfe_pkg;

    localparam int LED_IDX_W   = 6;
    localparam int LEVEL_W     = 8;
    localparam int TIME_W      = 8;
    localparam int DIV_W       = 8;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    localparam int TUSER_OP_BIT   = 0;
    localparam int TUSER_BUSY_BIT = 1;

    localparam logic [LEVEL_W-1:0] PERIOD_RST = 8'd10;

    typedef enum logic
    {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic
    {
        DIV_SEL_N    = 1'b0,
        DIV_SEL_STEP = 1'b1
    } div_sel_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_DIVN_WAIT,
        ST_STEP,
        ST_DIVS_WAIT,
        ST_SCAN,
        ST_SCAN_UPD,
        ST_FLUSH
    } state_t;

    typedef struct packed
    {
        logic [LEVEL_W-1:0] cur;
        logic [LEVEL_W-1:0] want;
        logic [LEVEL_W-1:0] step;
    } entry_t;

    typedef struct packed
    {
        logic     load_item;
        logic     rd_item;
        logic     rd_scan;
        logic     div_start;
        div_sel_t div_sel;
        logic     n_capture;
        logic     set_write;
        logic     scan_clear;
        logic     scan_inc;
        logic     tick_update;
        logic     flush;
    } cmd_t;

    typedef struct packed
    {
        op_t  item_op;
        logic strip_busy;
        logic idx_ok;
        logic div_done;
        logic n_zero;
        logic scan_end;
        logic scan_dirty;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

FILE: src/led_strip_fade_engine.sv
// ============================================================================
// led_strip_fade_engine
// Per-channel linear fade engine with set-target and tick items.
// ============================================================================
//  channel   dir  beat fields (low bit first)
//  s_axis    in   tdata: led_index, wanted_value, transition_time
//                 tuser: operation, strip_busy; tlast: batch_end
//  m_axis    out  tdata: pixel_index, pixel_value; tlast: last
//  cfg       in   data: update_period_ms
//
//  Set target: two divides (time by period, then distance by step count),
//  one when the step count is zero, none for an index beyond the strip.
//  Tick: scans every channel and updates each dirty one; a busy tick is dropped.
//  Stalls on m_axis hold the scan; up to two results wait (pending, output).
//  Reset clears marks and valid bits at once; no clearing pass.
// ============================================================================
module led_strip_fade_engine
#(
    parameter int NUM_LEDS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsfe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // led_index, wanted_value, transition_time
    input  logic [lsfe_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // operation, strip_busy
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lsfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // pixel_index, pixel_value
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsfe_pkg::LEVEL_W-1:0]        cfg_data
);

    `include "led_strip_fade_engine_defines.svh"

    lsfe_pkg::cmd_t    cmd;
    lsfe_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lsfe_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lsfe_datapath #(.NUM_LEDS(NUM_LEDS)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_data   (s_axis_tdata),
        .s_user   (s_axis_tuser),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_ready  (m_axis_tready),
        .cmd      (cmd),
        .status   (status),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

    `LSFE_ASSERT_IMP(a_idle_no_pend, s_axis_tready, !status.pend_valid, "pending result at idle")
    `LSFE_ASSERT_IMP(a_upd_no_overrun, cmd.tick_update, !status.pend_valid || status.out_free, "output overrun")
    `LSFE_ASSERT_IMP(a_set_in_range, cmd.set_write, status.idx_ok, "write beyond strip")
    `LSFE_ASSERT_NEXT(a_load_leaves_idle, cmd.load_item, !s_axis_tready, "ready after accept")

endmodule

FILE: src/lsfe_div.sv
// ============================================================================
// lsfe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module lsfe_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lsfe_pkg::DIV_W-1:0]   dividend,
    input  logic [lsfe_pkg::DIV_W-1:0]   divisor,
    output logic [lsfe_pkg::DIV_W-1:0]   quotient,
    output logic                         done
);

    localparam int W  = lsfe_pkg::DIV_W;
    localparam int CW = lsfe_pkg::DIV_CNT_W;

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic          fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        fits      = shifted >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? trial[W-1:0] : shifted[W-1:0];
            quo_next  = {quo_reg[W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: src/lsfe_datapath.sv
// ============================================================================
// lsfe_datapath
// Channel table, step calculation, fade update and output registers.
// ============================================================================
module lsfe_datapath
#(
    parameter int NUM_LEDS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lsfe_pkg::IN_TDATA_W-1:0]     s_data,
    input  logic [lsfe_pkg::IN_TUSER_W-1:0]     s_user,
    input  logic                                cfg_we,
    input  logic [lsfe_pkg::LEVEL_W-1:0]        cfg_data,
    input  logic                                m_ready,
    input  lsfe_pkg::cmd_t                      cmd,
    output lsfe_pkg::status_t                   status,
    output logic                                m_valid,
    output logic [lsfe_pkg::OUT_TDATA_W-1:0]    m_data,
    output logic                                m_last
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CW = $clog2(NUM_LEDS + 1);
    localparam int IW = lsfe_pkg::LED_IDX_W;
    localparam int LW = lsfe_pkg::LEVEL_W;

    logic [LW-1:0]       period_reg;
    lsfe_pkg::op_t       item_op_reg;
    logic                item_busy_reg;
    logic [IW-1:0]       item_idx_reg;
    logic [LW-1:0]       item_want_reg;
    logic [LW-1:0]       item_time_reg;

    lsfe_pkg::entry_t    mem [NUM_LEDS];
    lsfe_pkg::entry_t    rd_entry_reg;
    logic                rd_valid_reg;
    logic [NUM_LEDS-1:0] valid_reg;
    logic [NUM_LEDS-1:0] dirty_reg;

    logic [CW-1:0]       scan_reg;
    logic [LW-1:0]       n_reg;

    logic                pend_valid_reg;
    logic [IW-1:0]       pend_idx_reg;
    logic [LW-1:0]       pend_val_reg;
    logic                out_valid_reg;
    logic [IW-1:0]       out_idx_reg;
    logic [LW-1:0]       out_val_reg;
    logic                out_last_reg;

    logic [AW-1:0]       item_addr;
    logic [AW-1:0]       scan_addr;
    logic [LW-1:0]       cur_set;
    logic [LW-1:0]       diff;
    logic [LW-1:0]       step_set;
    logic [LW-1:0]       div_a;
    logic [LW-1:0]       div_b;
    logic [LW-1:0]       div_q;
    logic                div_done;
    logic [LW:0]         up_sum;
    logic [LW:0]         dn_lim;
    logic [LW-1:0]       new_level;
    logic                arrived;
    logic                out_free;

    lsfe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        item_addr = item_idx_reg[AW-1:0];
        scan_addr = scan_reg[AW-1:0];
        cur_set   = rd_valid_reg ? rd_entry_reg.cur : '0;
        diff      = (item_want_reg >= cur_set) ? (item_want_reg - cur_set)
                                               : (cur_set - item_want_reg);
        if (n_reg == '0)
            step_set = diff;
        else if (div_q == '0 && diff != '0)
            step_set = LW'(1);
        else
            step_set = div_q;

        if (cmd.div_sel == lsfe_pkg::DIV_SEL_N)
        begin
            div_a = item_time_reg;
            div_b = period_reg;
        end
        else
        begin
            div_a = diff;
            div_b = n_reg;
        end

        up_sum = {1'b0, rd_entry_reg.cur} + {1'b0, rd_entry_reg.step};
        dn_lim = {1'b0, rd_entry_reg.want} + {1'b0, rd_entry_reg.step};
        if (rd_entry_reg.want > rd_entry_reg.cur)
            new_level = (up_sum > {1'b0, rd_entry_reg.want}) ? rd_entry_reg.want
                                                             : up_sum[LW-1:0];
        else
            new_level = ({1'b0, rd_entry_reg.cur} >= dn_lim)
                      ? (rd_entry_reg.cur - rd_entry_reg.step) : rd_entry_reg.want;
        arrived  = (new_level == rd_entry_reg.want);
        out_free = !out_valid_reg || m_ready;
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg   <= lsfe_pkg::op_t'(s_user[lsfe_pkg::TUSER_OP_BIT]);
            item_busy_reg <= s_user[lsfe_pkg::TUSER_BUSY_BIT];
            item_idx_reg  <= s_data[IW-1:0];
            item_want_reg <= s_data[IW+LW-1:IW];
            item_time_reg <= s_data[IW+LW+lsfe_pkg::TIME_W-1:IW+LW];
        end
        if (cmd.n_capture)
            n_reg <= (period_reg == '0) ? '0 : div_q;
    end

    // channel table
    always_ff @(posedge clk)
    begin
        if (cmd.set_write)
            mem[item_addr] <= '{cur: cur_set, want: item_want_reg, step: step_set};
        else if (cmd.tick_update)
            mem[scan_addr] <= '{cur: new_level, want: rd_entry_reg.want,
                                step: rd_entry_reg.step};
        if (cmd.rd_item)
        begin
            rd_entry_reg <= mem[item_addr];
            rd_valid_reg <= valid_reg[item_addr];
        end
        else if (cmd.rd_scan)
        begin
            rd_entry_reg <= mem[scan_addr];
            rd_valid_reg <= valid_reg[scan_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= lsfe_pkg::PERIOD_RST;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                period_reg <= cfg_data;
            if (cmd.set_write)
            begin
                valid_reg[item_addr] <= 1'b1;
                dirty_reg[item_addr] <= 1'b1;
            end
            if (cmd.tick_update && arrived)
                dirty_reg[scan_addr] <= 1'b0;
            if (cmd.scan_clear)
                scan_reg <= '0;
            else if (cmd.scan_inc || cmd.tick_update)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.tick_update)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;
            if ((cmd.tick_update && pend_valid_reg) || cmd.flush)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.tick_update)
        begin
            pend_idx_reg <= IW'(scan_addr);
            pend_val_reg <= new_level;
        end
        if ((cmd.tick_update && pend_valid_reg) || cmd.flush)
        begin
            out_idx_reg  <= pend_idx_reg;
            out_val_reg  <= pend_val_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_comb
    begin
        status.item_op    = item_op_reg;
        status.strip_busy = item_busy_reg;
        status.idx_ok     = ({1'b0, item_idx_reg} < (IW+1)'(NUM_LEDS));
        status.div_done   = div_done;
        status.n_zero     = (n_reg == '0);
        status.scan_end   = (scan_reg == CW'(NUM_LEDS));
        status.scan_dirty = dirty_reg[scan_addr];
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = {{(lsfe_pkg::OUT_TDATA_W - IW - LW){1'b0}}, out_val_reg, out_idx_reg};
    assign m_last  = out_last_reg;

endmodule

FILE: src/lsfe_ctrl.sv
// ============================================================================
// lsfe_ctrl
// Sequencer for set-target and tick items.
// ============================================================================
module lsfe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  lsfe_pkg::status_t   status,
    output lsfe_pkg::cmd_t      cmd
);

    lsfe_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lsfe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            lsfe_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = lsfe_pkg::ST_DECODE;
                end
            end
            lsfe_pkg::ST_DECODE:
            begin
                if (status.item_op == lsfe_pkg::OP_SET)
                begin
                    if (status.idx_ok)
                    begin
                        cmd.rd_item   = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = lsfe_pkg::DIV_SEL_N;
                        state_next    = lsfe_pkg::ST_DIVN_WAIT;
                    end
                    else
                        state_next = lsfe_pkg::ST_IDLE;
                end
                else if (status.strip_busy)
                    state_next = lsfe_pkg::ST_IDLE;
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = lsfe_pkg::ST_SCAN;
                end
            end
            lsfe_pkg::ST_DIVN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.n_capture = 1'b1;
                    state_next    = lsfe_pkg::ST_STEP;
                end
            end
            lsfe_pkg::ST_STEP:
            begin
                if (status.n_zero)
                begin
                    cmd.set_write = 1'b1;
                    state_next    = lsfe_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = lsfe_pkg::DIV_SEL_STEP;
                    state_next    = lsfe_pkg::ST_DIVS_WAIT;
                end
            end
            lsfe_pkg::ST_DIVS_WAIT:
            begin
                cmd.div_sel = lsfe_pkg::DIV_SEL_STEP;
                if (status.div_done)
                begin
                    cmd.set_write = 1'b1;
                    state_next    = lsfe_pkg::ST_IDLE;
                end
            end
            lsfe_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                    state_next = lsfe_pkg::ST_FLUSH;
                else if (status.scan_dirty)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = lsfe_pkg::ST_SCAN_UPD;
                end
                else
                    cmd.scan_inc = 1'b1;
            end
            lsfe_pkg::ST_SCAN_UPD:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.tick_update = 1'b1;
                    state_next      = lsfe_pkg::ST_SCAN;
                end
            end
            lsfe_pkg::ST_FLUSH:
            begin
                if (!status.pend_valid)
                    state_next = lsfe_pkg::ST_IDLE;
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = lsfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
